// ===== rtl/spad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spad_pkg
// Shared types and constants of the sweep pulse angle decoder.
// ----------------------------------------------------------------------------
package spad_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_STEPS = 17;

	localparam logic [16:0] Q16_ONE     = 17'h10000;
	localparam logic [23:0] TICKS_MAX   = 24'hFFFFFF;
	localparam logic [30:0] ANGLE_MAX   = 31'h7FFFFFFF;
	// x / 10 == (x * DIV10_RECIP) >> 35 for any 32-bit x
	localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

	localparam logic [15:0] RST_SWEEP_LIMIT = 16'd800;
	localparam logic [15:0] RST_SYNC_LIMIT  = 16'd1584;
	localparam logic [31:0] RST_DEG_PER_TICK = 32'd5800480;
	localparam logic [15:0] RST_X_Q = 16'd655;
	localparam logic [15:0] RST_X_R = 16'd6554;
	localparam logic [15:0] RST_Y_Q = 16'd66;
	localparam logic [15:0] RST_Y_R = 16'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWEEP_LIMIT     = 3'd0,
		REG_SYNC_LIMIT      = 3'd1,
		REG_DEG_PER_TICK    = 3'd2,
		REG_X_PROCESS_NOISE = 3'd3,
		REG_X_MEASURE_NOISE = 3'd4,
		REG_Y_PROCESS_NOISE = 3'd5,
		REG_Y_MEASURE_NOISE = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_MEAS,
		MUL_EST,
		MUL_GAIN,
		MUL_VAR
	} mul_op_t;

	typedef struct packed {
		logic    load_in;
		logic    decode;
		logic    prep;
		logic    div_init;
		logic    div_step;
		logic    mul_en;
		mul_op_t mul_op;
		logic    acc_load;
		logic    acc_add;
		logic    commit;
	} cmd_t;

	typedef struct packed {
		logic meas;
		logic div_last;
	} status_t;

endpackage

// ===== rtl/spad_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spad_if
// Valid/ready channels of the decoder: pulse in, result out, register write.
// ----------------------------------------------------------------------------
interface spad_pulse_if;
	logic        valid;
	logic        ready;
	logic [1:0]  sensor;
	logic [31:0] start_time;
	logic [31:0] pulse_length;
	modport source(output valid, sensor, start_time, pulse_length, input ready);
	modport sink(input valid, sensor, start_time, pulse_length, output ready);
endinterface

interface spad_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_sensor;
	logic        axis;
	logic [23:0] sweep_ticks;
	logic [30:0] filtered_angle;
	modport source(output valid, out_sensor, axis, sweep_ticks, filtered_angle,
		input ready);
	modport sink(input valid, out_sensor, axis, sweep_ticks, filtered_angle,
		output ready);
endinterface

interface spad_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/spad_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spad_ctrl
// Sequencer: decode, angle scaling, gain division and filter update.
// ----------------------------------------------------------------------------
module spad_ctrl import spad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t st
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MUL_M, S_PREP, S_DINIT, S_DIV,
		S_MUL_A, S_MUL_B, S_MUL_C, S_WRITE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= S_DECODE;
						ready_q <= 1'b0;
					end
				end
				S_DECODE: begin
					if (st.meas) begin
						state_q <= S_MUL_M;
					end else begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_MUL_M: state_q <= S_PREP;
				S_PREP:  state_q <= S_DINIT;
				S_DINIT: state_q <= S_DIV;
				S_DIV: begin
					if (st.div_last)
						state_q <= S_MUL_A;
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_C;
				S_MUL_C: state_q <= S_WRITE;
				S_WRITE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						ready_q     <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_op  = MUL_MEAS;
		cmd.load_in = (state_q == S_IDLE) && in_valid && ready_q;
		unique case (state_q)
			S_DECODE: cmd.decode   = 1'b1;
			S_MUL_M: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MEAS;
			end
			S_PREP:  cmd.prep     = 1'b1;
			S_DINIT: cmd.div_init = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_MUL_A: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_EST;
			end
			S_MUL_B: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_op   = MUL_GAIN;
				cmd.acc_load = 1'b1;
			end
			S_MUL_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MUL_VAR;
				cmd.acc_add = 1'b1;
			end
			S_WRITE: cmd.commit = out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/spad_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spad_dp
// Datapath: per-sensor state, shared multiplier, gain divider, result word.
// ----------------------------------------------------------------------------
module spad_dp import spad_pkg::*; #(
	parameter int SENSORS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           sensor,
	input  logic [31:0]          start_time,
	input  logic [31:0]          pulse_length,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  cmd_t                 cmd,
	output status_t              st,
	output logic [1:0]           out_sensor,
	output logic                 axis,
	output logic [23:0]          sweep_ticks,
	output logic [30:0]          filtered_angle
);

	localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

	// configuration
	logic [15:0] sweep_limit_q, sync_limit_q;
	logic [31:0] dpt_q;
	logic [15:0] xq_q, xr_q, yq_q, yr_q;

	// per-sensor state
	logic [31:0] sync_q  [SENSORS];
	logic        seen_q  [SENSORS];
	logic        armed_q [SENSORS];
	logic        axy_q   [SENSORS];
	logic [31:0] xest_q  [SENSORS];
	logic [31:0] xvar_q  [SENSORS];
	logic [31:0] yest_q  [SENSORS];
	logic [31:0] yvar_q  [SENSORS];

	// latched word and working registers
	logic [1:0]  sensor_q;
	logic [31:0] start_q, len_q;
	logic [23:0] ticks_q;
	logic        axis_q;
	logic [63:0] prod_q;
	logic [49:0] acc_q;
	logic [30:0] meas_q;
	logic [31:0] p_q;
	logic [32:0] den_q;
	logic        den_zero_q;
	logic [33:0] rem_q;
	logic [16:0] nlo_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;

	logic [SIDX_W-1:0] idx;
	logic        sens_ok, is_sweep, is_sync, y_even;
	logic [59:0] d10_w;
	logic [31:0] diff_w;
	logic [23:0] ticks_w;
	logic [31:0] est_sel, var_sel;
	logic [15:0] q_sel, r_sel;
	logic [63:0] mrnd_w;
	logic [32:0] psum_w;
	logic [31:0] p_w;
	logic [32:0] den_w;
	logic [48:0] num_w;
	logic [33:0] t_w;
	logic        ge_w;
	logic [16:0] k_w, omk_w;
	logic [31:0] mul_a, mul_b;
	logic [31:0] est_new, var_new;
	logic [63:0] vrnd_w;

	assign idx      = SIDX_W'(sensor_q);
	assign sens_ok  = 6'(sensor_q) < 6'(SENSORS);
	assign is_sweep = len_q < {16'h0, sweep_limit_q};
	assign is_sync  = !is_sweep && (len_q < {16'h0, sync_limit_q});
	// bit 0 of (len / 16) / 10
	assign d10_w    = 60'(len_q[31:4]) * 60'(DIV10_RECIP);
	assign y_even   = !d10_w[35];
	assign diff_w   = start_q - sync_q[idx];
	assign ticks_w  = (diff_w > {8'h0, TICKS_MAX}) ? TICKS_MAX : diff_w[23:0];

	assign est_sel = axis_q ? yest_q[idx] : xest_q[idx];
	assign var_sel = axis_q ? yvar_q[idx] : xvar_q[idx];
	assign q_sel   = axis_q ? yq_q : xq_q;
	assign r_sel   = axis_q ? yr_q : xr_q;

	assign mrnd_w = prod_q + 64'd32768;
	assign psum_w = {1'b0, var_sel} + {17'h0, q_sel};
	assign p_w    = psum_w[32] ? 32'hFFFFFFFF : psum_w[31:0];
	assign den_w  = {1'b0, p_q} + {17'h0, r_sel};
	// p * 2^16 + den / 2
	assign num_w  = {1'b0, p_q, 16'h0} + {16'h0, den_w[32:1]};

	assign t_w  = {rem_q[32:0], nlo_q[16]};
	assign ge_w = t_w >= {1'b0, den_q};

	assign k_w   = den_zero_q ? 17'h0 : ((quot_q > Q16_ONE) ? Q16_ONE : quot_q);
	assign omk_w = Q16_ONE - k_w;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_MEAS: begin
				mul_a = dpt_q;
				mul_b = {8'h0, ticks_q};
			end
			MUL_EST: begin
				mul_a = est_sel;
				mul_b = {15'h0, omk_w};
			end
			MUL_GAIN: begin
				mul_a = {1'b0, meas_q};
				mul_b = {15'h0, k_w};
			end
			MUL_VAR: begin
				mul_a = p_q;
				mul_b = {15'h0, omk_w};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign est_new = acc_q[47:16];
	assign vrnd_w  = prod_q + 64'd32768;
	assign var_new = vrnd_w[47:16];

	assign st.meas     = sens_ok && is_sweep && armed_q[idx];
	assign st.div_last = (cnt_q == 5'd0);

	// config and per-sensor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_limit_q <= RST_SWEEP_LIMIT;
			sync_limit_q  <= RST_SYNC_LIMIT;
			dpt_q         <= RST_DEG_PER_TICK;
			xq_q          <= RST_X_Q;
			xr_q          <= RST_X_R;
			yq_q          <= RST_Y_Q;
			yr_q          <= RST_Y_R;
			for (int i = 0; i < SENSORS; i++) begin
				sync_q[i]  <= '0;
				seen_q[i]  <= 1'b0;
				armed_q[i] <= 1'b0;
				axy_q[i]   <= 1'b0;
				xest_q[i]  <= '0;
				xvar_q[i]  <= {15'h0, Q16_ONE};
				yest_q[i]  <= '0;
				yvar_q[i]  <= {15'h0, Q16_ONE};
			end
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SWEEP_LIMIT:     sweep_limit_q <= cfg_data[15:0];
					REG_SYNC_LIMIT:      sync_limit_q  <= cfg_data[15:0];
					REG_DEG_PER_TICK:    dpt_q         <= cfg_data;
					REG_X_PROCESS_NOISE: xq_q          <= cfg_data[15:0];
					REG_X_MEASURE_NOISE: xr_q          <= cfg_data[15:0];
					REG_Y_PROCESS_NOISE: yq_q          <= cfg_data[15:0];
					REG_Y_MEASURE_NOISE: yr_q          <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.decode && sens_ok) begin
				if (is_sweep) begin
					seen_q[idx] <= 1'b1;
				end else if (is_sync) begin
					sync_q[idx] <= start_q;
					if (seen_q[idx]) begin
						axy_q[idx]   <= y_even;
						armed_q[idx] <= 1'b1;
					end
				end
			end
			if (cmd.commit) begin
				armed_q[idx] <= 1'b0;
				if (axis_q) begin
					yest_q[idx] <= est_new;
					yvar_q[idx] <= var_new;
				end else begin
					xest_q[idx] <= est_new;
					xvar_q[idx] <= var_new;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sensor_q <= sensor;
			start_q  <= start_time;
			len_q    <= pulse_length;
		end
		if (cmd.decode) begin
			ticks_q <= ticks_w;
			axis_q  <= axy_q[idx];
		end
		if (cmd.mul_en)
			prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.prep) begin
			meas_q <= (|mrnd_w[63:47]) ? ANGLE_MAX : mrnd_w[46:16];
			p_q    <= p_w;
		end
		if (cmd.div_init) begin
			den_q      <= den_w;
			den_zero_q <= (den_w == 33'h0);
			rem_q      <= {2'b0, num_w[48:17]};
			nlo_q      <= num_w[16:0];
			quot_q     <= '0;
			cnt_q      <= 5'(DIV_STEPS - 1);
		end
		if (cmd.div_step) begin
			rem_q  <= ge_w ? (t_w - {1'b0, den_q}) : t_w;
			nlo_q  <= {nlo_q[15:0], 1'b0};
			quot_q <= {quot_q[15:0], ge_w};
			cnt_q  <= cnt_q - 5'd1;
		end
		if (cmd.acc_load)
			acc_q <= prod_q[49:0];
		if (cmd.acc_add)
			acc_q <= acc_q + prod_q[49:0] + 50'd32768;
		if (cmd.commit) begin
			out_sensor     <= sensor_q;
			axis           <= axis_q;
			sweep_ticks    <= ticks_q;
			filtered_angle <= est_new[30:0];
		end
	end

endmodule

// ===== rtl/sweep_pulse_angle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_pulse_angle_decoder
// Sorts light pulses into sync and sweep, turns sweep timing into an angle
// and smooths it with a per-sensor, per-axis scalar Kalman filter (Q16).
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                      handshake
//  -------  ---  ----------------------------------------  ---------
//  pulse    in   sensor, start_time, pulse_length          valid/ready
//  result   out  out_sensor, axis, sweep_ticks,            valid/ready
//                filtered_angle
//  cfg      in   index, data                               valid/ready
//
//  One pulse word at a time. A word that gives no result is accepted and
//  decoded only. A measured sweep is accepted and decoded, then runs the
//  angle multiply, prepare, divider load, 17 restoring gain-division steps,
//  the filter update on the shared 32x32 multiplier, and write-back.
//  The result sits in an output register; a new pulse is taken while it
//  waits, and the next result holds in the write-back step until it is free.
//  Reset clears all per-sensor state at once; no clearing pass. cfg is
//  always ready.
//
module sweep_pulse_angle_decoder import spad_pkg::*; #(
	parameter int SENSORS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	spad_pulse_if.sink    pulse,
	spad_result_if.source result,
	spad_cfg_if.sink      cfg
);

	cmd_t    cmd;
	status_t st;

	// registers are written the cycle they arrive
	assign cfg.ready = 1'b1;

	spad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pulse.valid),
		.in_ready  (pulse.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.st        (st)
	);

	spad_dp #(
		.SENSORS (SENSORS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.sensor         (pulse.sensor),
		.start_time     (pulse.start_time),
		.pulse_length   (pulse.pulse_length),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.cmd            (cmd),
		.st             (st),
		.out_sensor     (result.out_sensor),
		.axis           (result.axis),
		.sweep_ticks    (result.sweep_ticks),
		.filtered_angle (result.filtered_angle)
	);

endmodule

// ===== rtl/spad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spad_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module spad_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready
);

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before taken");

	// one pulse in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pulse taken while busy");

	// a result never follows its pulse in the very next cycle
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port stalled");

endmodule

bind sweep_pulse_angle_decoder spad_checker u_spad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pulse.valid),
	.in_ready  (pulse.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.cfg_ready (cfg.ready)
);
